// ===== rtl/dtk_pkg.sv =====
// Package for the top-k keeper: sizes, mode and status codes, and the command
// that passes from the front end to the back end.
// No dependencies.
package dtk_pkg;

	localparam int KEEP_DEPTH = 32;
	localparam int SEEN_DEPTH = 256;
	localparam int KIDX_W = $clog2(KEEP_DEPTH);
	localparam int KCNT_W = $clog2(KEEP_DEPTH + 1);
	localparam int SIDX_W = $clog2(SEEN_DEPTH);
	localparam int SCNT_W = $clog2(SEEN_DEPTH + 1);
	localparam int QDEPTH = 2;

	typedef enum logic [1:0] {
		MODE_PUSH  = 2'd0,
		MODE_DRAIN = 2'd1,
		MODE_CLEAR = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_INSERTED  = 3'd0,
		ST_REPLACED  = 3'd1,
		ST_REJECTED  = 3'd2,
		ST_DUPLICATE = 3'd3,
		ST_SEEN_FULL = 3'd4,
		ST_DRAINED   = 3'd5,
		ST_EMPTY     = 3'd6,
		ST_CLEARED   = 3'd7
	} status_t;

	// Command from the front end: a classified push, a drain or a clear.
	typedef struct packed {
		mode_t        mode;
		logic         is_new;   // push with a key not seen before and room to record it
		status_t      pre_st;   // duplicate or seen full when is_new is low
		logic [63:0]  key;
		logic [31:0]  score;
		logic [15:0]  tag;
	} cmd_t;

	typedef enum logic [1:0] {
		FS_IDLE = 2'd0,
		FS_SCAN = 2'd1,
		FS_PUT  = 2'd2
	} fstate_t;

	typedef enum logic [2:0] {
		BS_IDLE  = 3'd0,
		BS_FIND  = 3'd1,
		BS_SHIFT = 3'd2,
		BS_DRAIN = 3'd3,
		BS_OUT   = 3'd4
	} bstate_t;

endpackage

// ===== rtl/dtk_front.sv =====
// Front end: accepts input beats, checks push keys against the seen-key memory
// one entry a cycle, and hands commands to the queue.
// Depends on dtk_pkg.
module dtk_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          mode,
	input  logic [63:0]         item_key,
	input  logic [31:0]         candidate_score,
	input  logic [15:0]         item_tag,
	output logic                cmd_valid,
	input  logic                cmd_stall,
	output dtk_pkg::cmd_t       cmd
);
	import dtk_pkg::*;

	fstate_t                state_q, state_d;
	cmd_t                   cmd_q;
	logic [SCNT_W-1:0]      fill_q;
	logic [SCNT_W-1:0]      idx_q;
	logic [63:0]            seen_mem [SEEN_DEPTH];
	logic [63:0]            rd_s1;
	logic                   rd_vld_s1;
	logic                   hit_q;
	logic                   accept;
	logic                   rd_en;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != FS_IDLE);
	assign rd_en = (state_q == FS_SCAN) && (idx_q < fill_q);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			FS_IDLE: begin
				if (accept && mode_t'(mode) != MODE_NONE) begin
					if (mode_t'(mode) == MODE_PUSH) state_d = FS_SCAN;
					else state_d = FS_PUT;
				end
			end
			FS_SCAN: begin
				if (!rd_en && !rd_vld_s1) state_d = FS_PUT;
			end
			FS_PUT: begin
				if (!cmd_stall) state_d = FS_IDLE;
			end
			default: state_d = FS_IDLE;
		endcase
	end

	// Outputs toward the queue.
	always_comb begin
		cmd_valid = (state_q == FS_PUT);
		cmd = cmd_q;
		if (cmd_q.mode == MODE_PUSH) begin
			cmd.is_new = !hit_q && (fill_q < SCNT_W'(SEEN_DEPTH));
			cmd.pre_st = hit_q ? ST_DUPLICATE : ST_SEEN_FULL;
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_IDLE;
			fill_q <= '0;
			idx_q <= '0;
			hit_q <= 1'b0;
			rd_vld_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_vld_s1 <= rd_en;
			if (rd_en) idx_q <= idx_q + 1'b1;
			if (rd_vld_s1 && rd_s1 == cmd_q.key) hit_q <= 1'b1;
			if (accept) begin
				idx_q <= '0;
				hit_q <= 1'b0;
			end
			if (state_q == FS_PUT && !cmd_stall) begin
				if (cmd_q.mode == MODE_CLEAR) fill_q <= '0;
				else if (cmd.mode == MODE_PUSH && cmd.is_new) fill_q <= fill_q + 1'b1;
			end
		end
	end

	// Captured beat.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q.mode <= mode_t'(mode);
			cmd_q.is_new <= 1'b0;
			cmd_q.pre_st <= ST_DUPLICATE;
			cmd_q.key <= item_key;
			cmd_q.score <= candidate_score;
			cmd_q.tag <= item_tag;
		end
	end

	// Seen-key memory.
	always_ff @(posedge clk) begin
		if (rd_en) rd_s1 <= seen_mem[idx_q[SIDX_W-1:0]];
		if (state_q == FS_PUT && !cmd_stall && cmd.mode == MODE_PUSH && cmd.is_new)
			seen_mem[fill_q[SIDX_W-1:0]] <= cmd_q.key;
	end

`ifndef NO_ASSERTIONS
	a_fill_max: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= SCNT_W'(SEEN_DEPTH)) else $error("seen fill overflow");
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> idx_q < SCNT_W'(SEEN_DEPTH)) else $error("scan past end");
	a_put_from: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FS_PUT && $past(state_q) != FS_PUT) |->
		($past(state_q) == FS_IDLE || !$past(rd_vld_s1))) else $error("scan ended early");
`endif

endmodule

// ===== rtl/dtk_queue.sv =====
// Short command queue between front and back end.
// Depends on dtk_pkg.
module dtk_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_stall,
	input  dtk_pkg::cmd_t  wr_data,
	output logic           rd_valid,
	input  logic           rd_stall,
	output dtk_pkg::cmd_t  rd_data
);
	import dtk_pkg::*;

	localparam int PW = $clog2(QDEPTH);

	cmd_t            mem_q [QDEPTH];
	logic [PW-1:0]   wp_q, rp_q;
	logic [PW:0]     cnt_q;
	logic            wr, rd;

	assign wr_stall = (cnt_q == (PW+1)'(QDEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_data = mem_q[rp_q];
	assign wr = wr_valid && !wr_stall;
	assign rd = rd_valid && !rd_stall;

	// Pointers and count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(wr) - (PW+1)'(rd);
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

endmodule

// ===== rtl/dtk_back.sv =====
// Back end: keeps the sorted table of best entries, inserts by a search and
// one-entry-a-cycle shift, drains best first, and drives result beats.
// Depends on dtk_pkg.
module dtk_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [5:0]          cfg_wdata,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  dtk_pkg::cmd_t       cmd,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [2:0]          status,
	output logic [31:0]         out_score,
	output logic [63:0]         out_key,
	output logic [15:0]         out_tag,
	output logic [5:0]          held_count,
	output logic                last
);
	import dtk_pkg::*;

	typedef struct packed {
		logic [31:0] score;
		logic [63:0] key;
		logic [15:0] tag;
	} ent_t;

	bstate_t              state_q, state_d;
	ent_t                 tbl [KEEP_DEPTH];
	logic [5:0]           keep_q;
	logic [KCNT_W-1:0]    fill_q;
	logic [KCNT_W-1:0]    lim;
	logic [KCNT_W-1:0]    ptr_q;      // search position, then shift position
	logic [KCNT_W-1:0]    end_q;      // highest index that the shift fills
	cmd_t                 cmd_q;
	status_t              put_st;
	logic                 ovl_q;      // result beat waiting
	logic [2:0]           ost_q;
	ent_t                 oent_q;
	logic [5:0]           ocnt_q;
	logic                 olast_q;
	logic                 take, osend, ofree;
	logic                 found;

	assign take = cmd_valid && !cmd_stall;
	assign cmd_stall = (state_q != BS_IDLE);
	assign osend = ovl_q && !out_stall;
	assign ofree = !ovl_q || !out_stall;

	// Effective limit: zero acts as one, above the depth acts as the depth.
	always_comb begin
		if (keep_q == '0) lim = KCNT_W'(1);
		else if ({1'b0, keep_q} > 7'(KEEP_DEPTH)) lim = KCNT_W'(KEEP_DEPTH);
		else lim = KCNT_W'(keep_q);
	end

	// Outcome of a new push: room left, beats the worst entry, or rejected.
	always_comb begin
		if (fill_q < lim) put_st = ST_INSERTED;
		else if (fill_q != '0 && cmd.score > tbl[KIDX_W'(fill_q - 1'b1)].score)
			put_st = ST_REPLACED;
		else put_st = ST_REJECTED;
	end

	assign found = (ptr_q >= end_q) || (tbl[ptr_q[KIDX_W-1:0]].score < cmd_q.score);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			BS_IDLE: begin
				if (take) begin
					case (cmd.mode)
						MODE_PUSH:  state_d = cmd.is_new ? BS_FIND : BS_OUT;
						MODE_DRAIN: state_d = (fill_q == '0) ? BS_OUT : BS_DRAIN;
						default:    state_d = BS_OUT;
					endcase
				end
			end
			BS_FIND: begin
				if (found) state_d = BS_SHIFT;
			end
			BS_SHIFT: begin
				if (end_q <= ptr_q) state_d = BS_OUT;
			end
			BS_DRAIN: begin
				if (ofree && ptr_q + 1'b1 == fill_q) state_d = BS_IDLE;
			end
			BS_OUT: begin
				if (ofree) state_d = BS_IDLE;
			end
			default: state_d = BS_IDLE;
		endcase
	end

	// Result fields.
	always_comb begin
		out_valid = ovl_q;
		status = ost_q;
		out_score = oent_q.score;
		out_key = oent_q.key;
		out_tag = oent_q.tag;
		held_count = ocnt_q;
		last = olast_q;
	end

	// Control and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BS_IDLE;
			keep_q <= 6'd32;
			fill_q <= '0;
			ptr_q <= '0;
			end_q <= '0;
			ovl_q <= 1'b0;
			ost_q <= '0;
			oent_q <= '0;
			ocnt_q <= '0;
			olast_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) keep_q <= cfg_wdata;
			if (osend) ovl_q <= 1'b0;
			case (state_q)
				BS_IDLE: begin
					ptr_q <= '0;
					if (take && cmd.mode == MODE_PUSH && cmd.is_new) begin
						case (put_st)
							ST_INSERTED: end_q <= fill_q;
							ST_REPLACED: end_q <= fill_q - 1'b1;
							default:     end_q <= '0;
						endcase
					end
				end
				BS_FIND: begin
					if (!found) ptr_q <= ptr_q + 1'b1;
				end
				BS_SHIFT: begin
					if (end_q > ptr_q) end_q <= end_q - 1'b1;
					else if (cmd_q.pre_st == ST_INSERTED) fill_q <= fill_q + 1'b1;
				end
				BS_DRAIN: begin
					if (ofree) begin
						ovl_q <= 1'b1;
						ost_q <= ST_DRAINED;
						oent_q <= tbl[ptr_q[KIDX_W-1:0]];
						ocnt_q <= 6'(fill_q);
						olast_q <= (ptr_q + 1'b1 == fill_q);
						ptr_q <= ptr_q + 1'b1;
					end
				end
				BS_OUT: begin
					if (ofree) begin
						ovl_q <= 1'b1;
						oent_q <= '0;
						olast_q <= 1'b1;
						ocnt_q <= 6'(fill_q);
						case (cmd_q.mode)
							MODE_PUSH:  ost_q <= cmd_q.pre_st;
							MODE_DRAIN: ost_q <= ST_EMPTY;
							default: begin
								ost_q <= ST_CLEARED;
								ocnt_q <= '0;
								fill_q <= '0;
							end
						endcase
					end
				end
				default: ;
			endcase
		end
	end

	// Captured command; a new push records how it will touch the table.
	always_ff @(posedge clk) begin
		if (take) begin
			cmd_q.mode <= cmd.mode;
			cmd_q.is_new <= cmd.is_new;
			cmd_q.key <= cmd.key;
			cmd_q.score <= cmd.score;
			cmd_q.tag <= cmd.tag;
			if (cmd.mode == MODE_PUSH && cmd.is_new) cmd_q.pre_st <= put_st;
			else cmd_q.pre_st <= cmd.pre_st;
		end
	end

	// Table shift: move one entry down per cycle, then write the new item.
	always_ff @(posedge clk) begin
		if (state_q == BS_SHIFT && cmd_q.pre_st != ST_REJECTED) begin
			if (end_q > ptr_q)
				tbl[end_q[KIDX_W-1:0]] <= tbl[KIDX_W'(end_q - 1'b1)];
			else
				tbl[ptr_q[KIDX_W-1:0]] <= '{score: cmd_q.score, key: cmd_q.key,
					tag: cmd_q.tag};
		end
	end

`ifndef NO_ASSERTIONS
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= KCNT_W'(KEEP_DEPTH)) else $error("table overfull");
	a_drain_last: assert property (@(posedge clk) disable iff (!arst_n)
		(ovl_q && ost_q == ST_DRAINED && olast_q) |-> ocnt_q != '0) else $error("bad drain");
	a_shift_end: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BS_SHIFT |-> end_q >= ptr_q) else $error("shift underrun");
`endif

endmodule

// ===== rtl/dedup_top_k_keeper.sv =====
// Top k keeper with key deduplication: front end, command queue, back end.
// Depends on dtk_pkg, dtk_front, dtk_queue, dtk_back.
//
// Each push is checked against every recorded key, one per cycle, then its
// slot in the sorted table is found and entries are shifted one per cycle;
// front and back end overlap through a two-deep command queue. A drain
// sends one result beat per kept entry, one per cycle while out_stall is low.
module dedup_top_k_keeper (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [5:0]   keep_count,
	input  logic         in_valid,
	output logic         in_stall,
	input  logic [1:0]   mode,
	input  logic [63:0]  item_key,
	input  logic [31:0]  candidate_score,
	input  logic [15:0]  item_tag,
	output logic         out_valid,
	input  logic         out_stall,
	output logic [2:0]   status,
	output logic [31:0]  out_score,
	output logic [63:0]  out_key,
	output logic [15:0]  out_tag,
	output logic [5:0]   held_count,
	output logic         last
);
	import dtk_pkg::*;

	cmd_t  f_cmd, b_cmd;
	logic  f_valid, f_stall, b_valid, b_stall;

	dtk_front u_front (.clk, .arst_n, .in_valid, .in_stall, .mode, .item_key,
		.candidate_score, .item_tag, .cmd_valid(f_valid), .cmd_stall(f_stall),
		.cmd(f_cmd));

	dtk_queue u_queue (.clk, .arst_n, .wr_valid(f_valid), .wr_stall(f_stall),
		.wr_data(f_cmd), .rd_valid(b_valid), .rd_stall(b_stall), .rd_data(b_cmd));

	dtk_back u_back (.clk, .arst_n, .cfg_we, .cfg_wdata(keep_count),
		.cmd_valid(b_valid), .cmd_stall(b_stall), .cmd(b_cmd), .out_valid,
		.out_stall, .status, .out_score, .out_key, .out_tag, .held_count, .last);

endmodule
